### src/eapt_pkg.sv
// shared types and constants for the ellipse arc point and tangent block
// no dependencies

package eapt_pkg;

    localparam int TABLE_LEN = 24;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [30:0] PI_Q29 = 31'd1686629713;

    localparam logic [2:0] REG_ORIGIN = 3'd0;
    localparam logic [2:0] REG_AXIS_X = 3'd1;
    localparam logic [2:0] REG_AXIS_Y = 3'd2;
    localparam logic [2:0] REG_START  = 3'd3;
    localparam logic [2:0] REG_SPAN   = 3'd4;

    typedef logic [31:0] turn32_t;

    // arctangent of 2^-i in 2^-32 turn units
    function automatic turn32_t atan_turn32(input int i);
        turn32_t r;
        begin
            case (i)
                0:       r = 32'd536870912;
                1:       r = 32'd316933406;
                2:       r = 32'd167458907;
                3:       r = 32'd85004756;
                4:       r = 32'd42667331;
                5:       r = 32'd21354465;
                6:       r = 32'd10679838;
                7:       r = 32'd5340245;
                8:       r = 32'd2670163;
                9:       r = 32'd1335087;
                10:      r = 32'd667544;
                11:      r = 32'd333772;
                12:      r = 32'd166886;
                13:      r = 32'd83443;
                14:      r = 32'd41722;
                15:      r = 32'd20861;
                16:      r = 32'd10430;
                17:      r = 32'd5215;
                18:      r = 32'd2608;
                19:      r = 32'd1304;
                20:      r = 32'd652;
                21:      r = 32'd326;
                22:      r = 32'd163;
                23:      r = 32'd81;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

endpackage

### src/eapt_cordic.sv
// unrolled rotation-mode cordic, one register stage per iteration
// depends on eapt_pkg for the arctangent table and gain

module eapt_cordic #(
    parameter int STAGES = 16
) (
    input  logic                     clk,
    input  logic [STAGES-1:0]        en,
    input  logic [31:0]              phase,
    output logic signed [31:0]       x_out,
    output logic signed [31:0]       y_out,
    output logic [1:0]               quad_out
);

    logic signed [31:0] x_reg [STAGES];
    logic signed [31:0] y_reg [STAGES];
    logic signed [31:0] z_reg [STAGES];
    logic [1:0]         q_reg [STAGES];

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            logic signed [31:0] x_in;
            logic signed [31:0] y_in;
            logic signed [31:0] z_in;
            logic [1:0]         q_in;
            logic signed [31:0] x_next;
            logic signed [31:0] y_next;
            logic signed [31:0] z_next;

            if (k == 0) begin : g_first
                assign x_in = $signed(eapt_pkg::CORDIC_GAIN_Q30);
                assign y_in = '0;
                assign z_in = $signed({2'b00, phase[29:0]});
                assign q_in = phase[31:30];
            end else begin : g_next
                assign x_in = x_reg[k-1];
                assign y_in = y_reg[k-1];
                assign z_in = z_reg[k-1];
                assign q_in = q_reg[k-1];
            end

            always_comb
            begin
                if (!z_in[31])
                begin
                    x_next = x_in - (y_in >>> k);
                    y_next = y_in + (x_in >>> k);
                    z_next = z_in - $signed(eapt_pkg::atan_turn32(k));
                end
                else
                begin
                    x_next = x_in + (y_in >>> k);
                    y_next = y_in - (x_in >>> k);
                    z_next = z_in + $signed(eapt_pkg::atan_turn32(k));
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    x_reg[k] <= x_next;
                    y_reg[k] <= y_next;
                    z_reg[k] <= z_next;
                    q_reg[k] <= q_in;
                end
            end
        end
    endgenerate

    assign x_out    = x_reg[STAGES-1];
    assign y_out    = y_reg[STAGES-1];
    assign quad_out = q_reg[STAGES-1];

endmodule

### src/ellipse_arc_point_and_tangent.sv
// top level of the ellipse arc point and tangent evaluator
// depends on eapt_pkg and eapt_cordic

// One parameter value in, one point and tangent out, one transaction per clock cycle while
// the output is not stalled. Stages: phase, one per cordic iteration, then quadrant,
// products, rounding, tangent scaling and output. Stages advance independently, so bubbles
// close up and a held result does not block input until the pipeline is full. The user must
// write configuration registers only while idle; the block itself does not enforce this.

module ellipse_arc_point_and_tangent #(
    parameter int COORD_WIDTH   = 20,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [3*COORD_WIDTH-1:0]       cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [15:0]                    s_axis_tdata,   // param_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, zero pad
    output logic [((6*COORD_WIDTH+12+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW    = COORD_WIDTH;
    localparam int TW    = COORD_WIDTH + 4;
    localparam int AW    = ANGLE_WIDTH;
    localparam int PW    = ANGLE_WIDTH + 15;
    localparam int N     = (CORDIC_STAGES < eapt_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                                 : eapt_pkg::TABLE_LEN;
    localparam int L     = N + 6;
    localparam int S_Q   = N + 1;
    localparam int S_MUL = N + 2;
    localparam int S_SUM = N + 3;
    localparam int S_D   = N + 4;
    localparam int S_OUT = N + 5;
    localparam int MW    = 32 + CW;
    localparam int SW    = 33 + CW;
    localparam int PSW   = 4 + CW;
    localparam int VW    = 7 + CW;
    localparam int DW    = VW + 32;
    localparam int OW    = 6 * CW + 12;
    localparam int OBW   = ((OW + 7) / 8) * 8;

    logic [3*CW-1:0] origin_reg;
    logic [3*CW-1:0] axis_x_reg;
    logic [3*CW-1:0] axis_y_reg;
    logic [AW-1:0]   angle_start_reg;
    logic [AW-1:0]   angle_span_reg;
    logic [30:0]     w_reg;
    logic [30:0]     w_next;

    logic [L-1:0] valid_reg;
    logic [L-1:0] en;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg      <= '0;
            axis_x_reg      <= '0;
            axis_y_reg      <= '0;
            angle_start_reg <= '0;
            angle_span_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                eapt_pkg::REG_ORIGIN: origin_reg      <= cfg_data;
                eapt_pkg::REG_AXIS_X: axis_x_reg      <= cfg_data;
                eapt_pkg::REG_AXIS_Y: axis_y_reg      <= cfg_data;
                eapt_pkg::REG_START:  angle_start_reg <= cfg_data[AW-1:0];
                eapt_pkg::REG_SPAN:   angle_span_reg  <= cfg_data[AW-1:0];
                default: ;
            endcase
        end
    end

    // half span in radians, 29 fraction bits
    logic [AW+30:0] w_prod;
    assign w_prod = angle_span_reg * eapt_pkg::PI_Q29
                  + ((AW+31)'(1) << (AW - 1));
    assign w_next = w_prod[AW+30:AW];

    always_ff @(posedge clk)
    begin
        w_reg <= w_next;
    end

    // stage handshake chain
    genvar i;
    generate
        for (i = 0; i < L - 1; i++) begin : g_en
            assign en[i] = !valid_reg[i] || en[i+1];
        end
    endgenerate
    assign en[L-1] = !valid_reg[L-1] || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int j = 0; j < L; j++)
            begin
                if (en[j])
                begin
                    valid_reg[j] <= (j == 0) ? s_axis_tvalid : valid_reg[(j == 0) ? 0 : j-1];
                end
            end
        end
    end

    assign s_axis_tready = en[0];
    assign m_axis_tvalid = valid_reg[L-1];

    // phase stage
    logic signed [16:0]   t_val;
    logic signed [AW+17:0] t_prod;
    logic [PW-1:0]        ph_full;
    logic [31:0]          phase_next;
    logic [31:0]          phase_reg;

    assign t_val   = $signed({s_axis_tdata[15], s_axis_tdata}) + 17'sd16384;
    assign t_prod  = t_val * $signed({1'b0, angle_span_reg});
    assign ph_full = {angle_start_reg, 15'd0} + t_prod[PW-1:0];

    generate
        if (PW > 32) begin : g_ph_trunc
            assign phase_next = ph_full[PW-1:PW-32];
        end else if (PW == 32) begin : g_ph_same
            assign phase_next = ph_full;
        end else begin : g_ph_ext
            assign phase_next = {ph_full, {(32-PW){1'b0}}};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            phase_reg <= phase_next;
        end
    end

    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [1:0]         cq;

    eapt_cordic #(
        .STAGES (N)
    ) u_cordic (
        .clk      (clk),
        .en       (en[N:1]),
        .phase    (phase_reg),
        .x_out    (cx),
        .y_out    (cy),
        .quad_out (cq)
    );

    // quadrant stage
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;

    always_ff @(posedge clk)
    begin
        if (en[S_Q])
        begin
            case (cq)
                2'd1:
                begin
                    cos_reg <= -cy;
                    sin_reg <= cx;
                end
                2'd2:
                begin
                    cos_reg <= -cx;
                    sin_reg <= -cy;
                end
                2'd3:
                begin
                    cos_reg <= cy;
                    sin_reg <= -cx;
                end
                default:
                begin
                    cos_reg <= cx;
                    sin_reg <= cy;
                end
            endcase
        end
    end

    logic signed [TW-1:0] tan_out [3];
    logic signed [CW-1:0] pos_out [3];

    generate
        for (i = 0; i < 3; i++) begin : g_axis
            logic signed [CW-1:0]  ax;
            logic signed [CW-1:0]  ay;
            logic signed [CW-1:0]  org;
            logic signed [MW-1:0]  cax_reg;
            logic signed [MW-1:0]  say_reg;
            logic signed [MW-1:0]  cay_reg;
            logic signed [MW-1:0]  sax_reg;
            logic signed [SW-1:0]  psum;
            logic signed [SW-1:0]  vsum;
            logic signed [SW-1:0]  psh;
            logic signed [SW-1:0]  vsh;
            logic signed [PSW-1:0] p_full;
            logic signed [CW-1:0]  p_sat;
            logic signed [CW-1:0]  pos_reg [3];
            logic signed [VW-1:0]  v_reg;
            logic signed [DW-1:0]  d_reg;
            logic signed [DW-1:0]  d_sh;
            logic signed [TW-1:0]  d_sat;
            logic signed [TW-1:0]  tan_reg;

            assign ax  = axis_x_reg[i*CW +: CW];
            assign ay  = axis_y_reg[i*CW +: CW];
            assign org = origin_reg[i*CW +: CW];

            always_ff @(posedge clk)
            begin
                if (en[S_MUL])
                begin
                    cax_reg <= cos_reg * ax;
                    say_reg <= sin_reg * ay;
                    cay_reg <= cos_reg * ay;
                    sax_reg <= sin_reg * ax;
                end
            end

            assign psum   = SW'(cax_reg) + SW'(say_reg) + (SW'(1) <<< 29);
            assign vsum   = SW'(cay_reg) - SW'(sax_reg) + (SW'(1) <<< 25);
            assign psh    = psum >>> 30;
            assign vsh    = vsum >>> 26;
            assign p_full = PSW'(psh) + PSW'(org);

            always_comb
            begin
                if (p_full[PSW-1] && !(&p_full[PSW-2:CW-1]))
                begin
                    p_sat = {1'b1, {(CW-1){1'b0}}};
                end
                else if (!p_full[PSW-1] && (|p_full[PSW-2:CW-1]))
                begin
                    p_sat = {1'b0, {(CW-1){1'b1}}};
                end
                else
                begin
                    p_sat = p_full[CW-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[S_SUM])
                begin
                    pos_reg[0] <= p_sat;
                    v_reg      <= vsh[VW-1:0];
                end
                if (en[S_D])
                begin
                    pos_reg[1] <= pos_reg[0];
                    d_reg      <= v_reg * $signed({1'b0, w_reg});
                end
            end

            assign d_sh = (d_reg + (DW'(1) <<< 32)) >>> 33;

            always_comb
            begin
                if (d_sh[DW-1] && !(&d_sh[DW-2:TW-1]))
                begin
                    d_sat = {1'b1, {(TW-1){1'b0}}};
                end
                else if (!d_sh[DW-1] && (|d_sh[DW-2:TW-1]))
                begin
                    d_sat = {1'b0, {(TW-1){1'b1}}};
                end
                else
                begin
                    d_sat = d_sh[TW-1:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[S_OUT])
                begin
                    pos_reg[2] <= pos_reg[1];
                    tan_reg    <= d_sat;
                end
            end

            assign pos_out[i] = pos_reg[2];
            assign tan_out[i] = tan_reg;
        end
    endgenerate

    assign m_axis_tdata = OBW'({tan_out[2], tan_out[1], tan_out[0],
                                pos_out[2], pos_out[1], pos_out[0]});

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted transaction did not enter the first stage");

    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> valid_reg[0] && valid_reg[L-1])
        else $error("input stalled with room in the pipeline");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[L-1] && !m_axis_tready |=> valid_reg[L-1] && $stable(m_axis_tdata))
        else $error("stalled output stage lost or changed a transaction");

    a_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
        angle_span_reg == '0 |=> w_reg == '0)
        else $error("zero span gave a nonzero tangent scale");

endmodule
